// File: rtl/core/assert_macros.svh
// Assertion macros used by the top RTL file of the edge magnitude block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

// File: rtl/core/sem_pkg.sv
// Shared types, constants and the square root step of the edge magnitude block.
`timescale 1ns / 1ps
`default_nettype none
package sem_pkg;

	localparam int PIX_W        = 8;
	localparam int COL_W        = 11;
	localparam int ROW_W        = 12;
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int CFG_W        = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int GRAD_W       = 11;
	localparam int ENERGY_W     = 21;
	localparam int SQ_W         = 17;
	localparam int SQRT_STEPS   = 8;

	localparam int DEF_MAX_WIDTH = 2048;
	localparam int MIN_DIM       = 3;

	localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT   = 13'd4096;
	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [PIX_W-1:0]        MAG_MAX      = 8'd255;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             frame_end;
	} sem_tag_t;

	typedef struct packed {
		logic [SQ_W-1:0] rem;
		logic [SQ_W-1:0] root;
	} sqrt_t;

	function automatic sqrt_t sqrt_step(input sqrt_t cur, input int unsigned k);
		logic [SQ_W-1:0] one_bit;
		logic [SQ_W-1:0] trial;
		sqrt_t           nxt;
		one_bit = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - k));
		trial   = cur.root + one_bit;
		if (cur.rem >= trial) begin
			nxt.rem  = cur.rem - trial;
			nxt.root = (cur.root >> 1) + one_bit;
		end else begin
			nxt.rem  = cur.rem;
			nxt.root = cur.root >> 1;
		end
		return nxt;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/sem_magnitude.sv
// Gradient energy, pipelined floor square root and clamp with output register.
`timescale 1ns / 1ps
`default_nettype none
module sem_magnitude import sem_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [GRAD_W-1:0] gx,
	input  wire logic signed [GRAD_W-1:0] gy,
	input  wire sem_tag_t                 in_tag,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [PIX_W-1:0]              magnitude,
	output sem_tag_t                      out_tag
);

	logic signed [2*GRAD_W-1:0] sq_x;
	logic signed [2*GRAD_W-1:0] sq_y;
	logic [ENERGY_W-1:0]        energy;

	logic                valid_s3;
	logic [ENERGY_W-1:0] energy_s3;
	sem_tag_t            tag_s3;

	logic     valid_s4;
	logic     sat_s4;
	sqrt_t    sq_s4;
	sem_tag_t tag_s4;

	logic             out_valid_q;
	logic [PIX_W-1:0] mag_q;
	sem_tag_t         tag_q;

	logic  rdy_out, rdy_s4, rdy_s3;
	sqrt_t st_a, st_b;

	assign rdy_out  = !out_valid_q || !out_stall;
	assign rdy_s4   = !valid_s4 || rdy_out;
	assign rdy_s3   = !valid_s3 || rdy_s4;
	assign in_stall = !rdy_s3;

	assign sq_x   = gx * gx;
	assign sq_y   = gy * gy;
	assign energy = sq_x[ENERGY_W-1:0] + sq_y[ENERGY_W-1:0];

	always_comb begin
		st_a.rem  = SQ_W'(energy_s3[15:0]);
		st_a.root = '0;
		for (int k = 0; k < SQRT_STEPS / 2; k++) begin
			st_a = sqrt_step(st_a, k);
		end
		st_b = sq_s4;
		for (int k = SQRT_STEPS / 2; k < SQRT_STEPS; k++) begin
			st_b = sqrt_step(st_b, k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (rdy_s3) valid_s3 <= in_valid;
			if (rdy_s4) valid_s4 <= valid_s3;
			if (rdy_out) out_valid_q <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid) begin
			energy_s3 <= energy;
			tag_s3    <= in_tag;
		end
		if (rdy_s4 && valid_s3) begin
			sat_s4 <= |energy_s3[ENERGY_W-1:16];
			sq_s4  <= st_a;
			tag_s4 <= tag_s3;
		end
		if (rdy_out && valid_s4) begin
			mag_q <= sat_s4 ? MAG_MAX : st_b.root[PIX_W-1:0];
			tag_q <= tag_s4;
		end
	end

	assign out_valid = out_valid_q;
	assign magnitude = mag_q;
	assign out_tag   = tag_q;

endmodule
`default_nettype wire

// File: rtl/core/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster-order grayscale pixel stream.
//
// Pixels enter on pixel_valid / pixel_stall, one word per pixel in raster
// order; results leave on result_valid / result_stall, one word per interior
// pixel with its column, row, clamped magnitude and a frame_end flag on the
// last interior pixel. Border pixels give no word.
// Throughput: one pixel per clock while result_stall is low. Two line stores
// with a registered read port are read at the column address as a pixel is
// taken and written back as it leaves the first stage; the square root is
// split over two pipeline stages. While result_stall is high, pixels keep
// entering until the pipeline stages fill, then pixel_stall rises; nothing
// is dropped. Reset clears the counters, the window and the valid bits;
// image size returns to 640 x 480. Line stores are not cleared: every entry
// is written before a result uses it. Size registers are written over
// cfg_write, cfg_index, cfg_data only while the stream is idle; the user is
// bound to this, not the block. Counters wrap after the last pixel.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sobel_edge_magnitude import sem_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 pixel_valid,
	output logic                      pixel_stall,
	input  wire logic [PIX_W-1:0]     pixel_value,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output logic [COL_W-1:0]          out_col,
	output logic [ROW_W-1:0]          out_row,
	output logic [PIX_W-1:0]          magnitude,
	output logic                      frame_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int EW = ($clog2(MAX_WIDTH + 1) > WIDTH_REG_W) ?
		$clog2(MAX_WIDTH + 1) : WIDTH_REG_W;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [EW-1:0]           eff_w;
	logic [HEIGHT_REG_W-1:0] eff_h;

	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;
	logic [COL_W:0]          col_inc;
	logic [ROW_W:0]          row_inc;
	logic                    last_col, last_row;

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
	logic [AW-1:0]    rd_addr;

	logic             pix_acc;
	logic             valid_s1, emit_s1, last_s1;
	logic [PIX_W-1:0] pix_s1, upper_s1, middle_s1;
	logic [AW-1:0]    addr_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROW_W-1:0] row_s1;
	logic             s1_fire;

	logic [PIX_W-1:0] win_q [6];

	logic                     valid_s2;
	logic signed [GRAD_W-1:0] gx_s2, gy_s2;
	sem_tag_t                 tag_s2;
	logic                     ready_s2;
	logic                     mag_stall;

	logic [9:0]               gx_pos, gx_neg, gy_pos, gy_neg;
	logic signed [GRAD_W-1:0] gx, gy;
	sem_tag_t                 res_tag;

	always_comb begin
		eff_w = EW'(width_q);
		if (eff_w < EW'(MIN_DIM)) eff_w = EW'(MIN_DIM);
		else if (eff_w > EW'(MAX_WIDTH)) eff_w = EW'(MAX_WIDTH);
		eff_h = height_q;
		if (eff_h < HEIGHT_REG_W'(MIN_DIM)) eff_h = HEIGHT_REG_W'(MIN_DIM);
		else if (eff_h > MAX_HEIGHT) eff_h = MAX_HEIGHT;
	end

	assign col_inc  = {1'b0, col_q} + (COL_W + 1)'(1);
	assign row_inc  = {1'b0, row_q} + (ROW_W + 1)'(1);
	assign last_col = EW'(col_inc) >= eff_w;
	assign last_row = row_inc >= eff_h;
	assign rd_addr  = AW'(col_q);

	assign ready_s2    = !valid_s2 || !mag_stall;
	assign s1_fire     = valid_s1 && ready_s2;
	assign pixel_stall = valid_s1 && !ready_s2;
	assign pix_acc     = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// advance raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_acc) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[ROW_W-1:0];
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) upper_s1 <= upper_mem[rd_addr];
		if (s1_fire) upper_mem[addr_s1] <= middle_s1;
	end

	always_ff @(posedge clk) begin
		if (pix_acc) middle_s1 <= middle_mem[rd_addr];
		if (s1_fire) middle_mem[addr_s1] <= pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!valid_s1 || ready_s2) valid_s1 <= pix_acc;
			if (ready_s2) valid_s2 <= s1_fire && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			pix_s1  <= pixel_value;
			addr_s1 <= rd_addr;
			col_s1  <= col_q - COL_W'(1);
			row_s1  <= row_q - ROW_W'(1);
			emit_s1 <= (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
			last_s1 <= last_col && last_row;
		end
	end

	// shift window left, new column enters on the right
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= '0;
		end else if (s1_fire) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= upper_s1;
			win_q[4] <= middle_s1;
			win_q[5] <= pix_s1;
		end
	end

	always_comb begin
		gx_pos = 10'(upper_s1) + {1'b0, middle_s1, 1'b0} + 10'(pix_s1);
		gx_neg = 10'(win_q[0]) + {1'b0, win_q[1], 1'b0} + 10'(win_q[2]);
		gy_pos = 10'(win_q[2]) + {1'b0, win_q[5], 1'b0} + 10'(pix_s1);
		gy_neg = 10'(win_q[0]) + {1'b0, win_q[3], 1'b0} + 10'(upper_s1);
		gx     = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
		gy     = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && s1_fire) begin
			gx_s2            <= gx;
			gy_s2            <= gy;
			tag_s2.col       <= col_s1;
			tag_s2.row       <= row_s1;
			tag_s2.frame_end <= last_s1;
		end
	end

	sem_magnitude u_mag (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s2),
		.in_stall  (mag_stall),
		.gx        (gx_s2),
		.gy        (gy_s2),
		.in_tag    (tag_s2),
		.out_valid (result_valid),
		.out_stall (result_stall),
		.magnitude (magnitude),
		.out_tag   (res_tag)
	);

	assign out_col   = res_tag.col;
	assign out_row   = res_tag.row;
	assign frame_end = res_tag.frame_end;

	`ASSERT_NEVER(a_result_on_border, clk, arst_n,
		result_valid && (out_col == '0 || out_row == '0), "result word on a border pixel")
	`ASSERT_CLK(a_col_step, clk, arst_n,
		pix_acc |=> (col_q == '0 || col_q == COL_W'($past(col_q) + COL_W'(1))),
		"column counter skipped")
	`ASSERT_CLK(a_row_on_wrap, clk, arst_n,
		!$stable(row_q) |-> (col_q == '0), "row advanced without column wrap")

endmodule
`default_nettype wire

// File: verif/sobel_edge_magnitude_checker.sv
// Checker for the Sobel edge magnitude block: predicts each result word and compares.
`timescale 1ns / 1ps
module sobel_edge_magnitude_checker import sem_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 pixel_valid,
	input  logic                 pixel_stall,
	input  logic [PIX_W-1:0]     pixel_value,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  logic [COL_W-1:0]     out_col,
	input  logic [ROW_W-1:0]     out_row,
	input  logic [PIX_W-1:0]     magnitude,
	input  logic                 frame_end,
	output int                   fail_count,
	output int                   pending,
	output int                   frame_cols,
	output int                   frame_rows,
	output logic                 frame_last
);

	localparam int LINE_DEPTH = DEF_MAX_WIDTH;

	typedef struct packed {
		sem_tag_t         pos;
		logic [PIX_W-1:0] mag;
	} gradient_word_t;

	logic [WIDTH_REG_W-1:0]  width_reg;
	logic [HEIGHT_REG_W-1:0] height_reg;
	logic [PIX_W-1:0]        upper_line [LINE_DEPTH];
	logic [PIX_W-1:0]        middle_line [LINE_DEPTH];
	logic [PIX_W-1:0]        win [6];
	logic [COL_W-1:0]        col;
	logic [ROW_W-1:0]        row;
	gradient_word_t          due_magnitudes [$];
	int                      fails = 0;

	function automatic int clamp_dim(input int v, input int hi);
		if (v < MIN_DIM) return MIN_DIM;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic logic [PIX_W-1:0] gradient_root(input int unsigned energy);
		int unsigned root;
		int unsigned trial;
		root = 0;
		for (int b = 11; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (trial * trial <= energy) root = trial;
		end
		return (root > MAG_MAX) ? MAG_MAX : PIX_W'(root);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
			fails++;
		end
	endtask

	assign fail_count = fails;
	assign frame_cols = clamp_dim(int'(width_reg), DEF_MAX_WIDTH);
	assign frame_rows = clamp_dim(int'(height_reg), int'(MAX_HEIGHT));
	assign frame_last = (int'(col) + 1 >= frame_cols) && (int'(row) + 1 >= frame_rows);

	always @(posedge clk or negedge arst_n) begin : predict
		gradient_word_t want;
		int c, r, idx, tr, mr, br, tl, ml, bl, tm, bm, gx, gy;
		if (!arst_n) begin
			width_reg  <= WIDTH_RESET;
			height_reg <= HEIGHT_RESET;
			col        <= '0;
			row        <= '0;
			for (int i = 0; i < 6; i++) win[i] <= '0;
			due_magnitudes.delete();
			pending    <= 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == REG_IMAGE_WIDTH) width_reg <= cfg_data[WIDTH_REG_W-1:0];
				else if (cfg_index == REG_IMAGE_HEIGHT) height_reg <= cfg_data;
			end

			if (result_valid && !result_stall) begin
				if (due_magnitudes.size() == 0) begin
					$display("%0t: result expected none, actual col %0d row %0d magnitude %0d end %0d",
						$time, out_col, out_row, magnitude, frame_end);
					fails++;
				end else begin
					want = due_magnitudes.pop_front();
					check_field("out_col", 32'(want.pos.col), 32'(out_col));
					check_field("out_row", 32'(want.pos.row), 32'(out_row));
					check_field("magnitude", 32'(want.mag), 32'(magnitude));
					check_field("frame_end", 32'(want.pos.frame_end), 32'(frame_end));
				end
			end

			if (pixel_valid && !pixel_stall) begin
				c   = int'(col);
				r   = int'(row);
				idx = c % LINE_DEPTH;
				tr  = int'(upper_line[idx]);
				mr  = int'(middle_line[idx]);
				br  = int'(pixel_value);
				tl  = int'(win[0]);
				ml  = int'(win[1]);
				bl  = int'(win[2]);
				tm  = int'(win[3]);
				bm  = int'(win[5]);
				if (r >= 2 && c >= 2) begin
					gx = (tr + 2 * mr + br) - (tl + 2 * ml + bl);
					gy = (bl + 2 * bm + br) - (tl + 2 * tm + tr);
					want.pos.col       = COL_W'(c - 1);
					want.pos.row       = ROW_W'(r - 1);
					want.pos.frame_end = frame_last;
					want.mag           = gradient_root(gx * gx + gy * gy);
					due_magnitudes.push_back(want);
				end
				win[0] <= win[3];
				win[1] <= win[4];
				win[2] <= win[5];
				win[3] <= PIX_W'(tr);
				win[4] <= PIX_W'(mr);
				win[5] <= pixel_value;
				upper_line[idx]  <= PIX_W'(mr);
				middle_line[idx] <= pixel_value;
				if (c + 1 >= frame_cols) begin
					col <= '0;
					row <= (r + 1 >= frame_rows) ? '0 : ROW_W'(r + 1);
				end else begin
					col <= COL_W'(c + 1);
				end
			end

			pending <= due_magnitudes.size();
		end
	end

endmodule

// File: verif/sobel_edge_magnitude_tb.sv
// Testbench top for the Sobel edge magnitude block: pixel stimulus, result stalls, size writes, idling and verdict.
`timescale 1ns / 1ps
module sobel_edge_magnitude_tb;
	import sem_pkg::*;

	localparam int CYCLE_LIMIT   = 1_000_000;
	localparam int RANDOM_PIXELS = 1450;
	localparam int CALM_PIXELS   = 150;
	localparam int DRAIN_CYCLES  = 10;
	localparam int WIDE_PIXELS   = 45;

	typedef enum int {
		PIX_UNIFORM,
		PIX_EXTREME,
		PIX_SMOOTH
	} pixel_mode_t;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_write    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_IMAGE_WIDTH;
	logic [CFG_W-1:0]     cfg_data     = '0;
	logic                 pixel_valid  = 1'b0;
	logic [PIX_W-1:0]     pixel_value  = '0;
	logic                 result_stall = 1'b0;

	logic                 pixel_stall;
	logic                 result_valid;
	logic [COL_W-1:0]     out_col;
	logic [ROW_W-1:0]     out_row;
	logic [PIX_W-1:0]     magnitude;
	logic                 frame_end;

	int                   fail_count;
	int                   pending;
	int                   frame_cols;
	int                   frame_rows;
	logic                 frame_last;

	int                   cycles     = 0;
	int                   sent       = 0;
	int                   stall_left = 0;
	bit                   quiet_send = 1'b0;
	bit                   quiet_recv = 1'b0;
	bit                   calm       = 1'b0;

	sobel_edge_magnitude u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_value  (pixel_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_col      (out_col),
		.out_row      (out_row),
		.magnitude    (magnitude),
		.frame_end    (frame_end)
	);

	sobel_edge_magnitude_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_value  (pixel_value),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_col      (out_col),
		.out_row      (out_row),
		.magnitude    (magnitude),
		.frame_end    (frame_end),
		.fail_count   (fail_count),
		.pending      (pending),
		.frame_cols   (frame_cols),
		.frame_rows   (frame_rows),
		.frame_last   (frame_last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (calm || quiet_recv) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left   <= stall_left - 1;
			result_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left   <= $urandom_range(0, 5);
			result_stall <= 1'b1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	function automatic logic [PIX_W-1:0] pick_pixel(input pixel_mode_t mode, input int base);
		case (mode)
			PIX_EXTREME: return $urandom_range(0, 1) ? {PIX_W{1'b1}} : '0;
			PIX_SMOOTH:  return PIX_W'(base + $urandom_range(0, 15));
			default:     return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	// hold the word until taken
	task automatic send_pixel(input logic [PIX_W-1:0] v);
		int gap;
		if (!calm && !quiet_send && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 6);
			pixel_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_valid <= 1'b1;
		pixel_value <= v;
		@(posedge clk);
		while (pixel_stall) @(posedge clk);
		sent++;
	endtask

	task automatic finish_frame(input pixel_mode_t mode);
		int base;
		bit done;
		base = $urandom_range(0, 240);
		done = 1'b0;
		while (!done) begin
			send_pixel(pick_pixel(mode, base));
			done = frame_last;
		end
	endtask

	task automatic wait_idle();
		pixel_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		int          n;
		int          stop_at;
		pixel_mode_t mode;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest frame: strong vertical edge, then flat, then clamped sizes
		write_reg(REG_IMAGE_WIDTH, 13'd3);
		write_reg(REG_IMAGE_HEIGHT, 13'd3);
		for (int r = 0; r < 3; r++) begin
			send_pixel(8'd0);
			send_pixel(8'd128);
			send_pixel(8'hFF);
		end
		repeat (9) send_pixel(8'hFF);
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd0);
		write_reg(REG_IMAGE_HEIGHT, 13'd0);
		finish_frame(PIX_EXTREME);
		wait_idle();

		// widest rows, then shrink the frame in the middle of a row
		write_reg(REG_IMAGE_WIDTH, 13'h1FFF);
		write_reg(REG_IMAGE_HEIGHT, 13'h1FFF);
		repeat (WIDE_PIXELS) send_pixel(pick_pixel(PIX_UNIFORM, 0));
		wait_idle();
		write_reg(REG_IMAGE_WIDTH, 13'd4);
		write_reg(REG_IMAGE_HEIGHT, 13'd4);
		finish_frame(PIX_UNIFORM);

		stop_at = sent + RANDOM_PIXELS;
		while (sent < stop_at) begin
			calm       = (sent >= stop_at - CALM_PIXELS);
			quiet_send = ($urandom_range(0, 3) == 0);
			quiet_recv = ($urandom_range(0, 3) == 0);
			wait_idle();
			if ($urandom_range(0, 3) != 0) begin
				if ($urandom_range(0, 11) == 0)
					write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)),
						WIDTH_REG_W'($urandom_range(0, 40))});
				else
					write_reg(REG_IMAGE_WIDTH, {1'($urandom_range(0, 1)),
						WIDTH_REG_W'($urandom_range(0, 14))});
			end
			if ($urandom_range(0, 3) != 0)
				write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 9)));
			mode = pixel_mode_t'($urandom_range(0, 2));
			if ($urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, frame_cols * frame_rows - 1);
				repeat (n) send_pixel(pick_pixel(mode, 100));
				wait_idle();
				if ($urandom_range(0, 1) != 0)
					write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(0, frame_cols)));
				if ($urandom_range(0, 1) != 0)
					write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(0, 12)));
			end
			finish_frame(mode);
		end

		wait_idle();
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
